/* hdl/efr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// efr_pkg
// Shared types and codes for the escaped frame receiver: action and status
// codes, receiver modes, config register indexes and the result record.
// ----------------------------------------------------------------------------
package efr_pkg;

  // fixed field widths
  localparam int BYTE_W   = 8;
  localparam int IDX_W    = 5;
  localparam int LEN_W    = 6;
  localparam int STATUS_W = 4;
  localparam int ACTION_W = 2;
  localparam int CFG_IDX_W = 2;

  // result queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_LVL_W = $clog2(QUEUE_DEPTH + 1);

  // action codes; the unused code behaves as a read
  localparam logic [ACTION_W-1:0] ACT_RECEIVE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_READ    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd2;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE = 2'd2;

  // config register reset values
  localparam logic [BYTE_W-1:0] START_RST  = 8'd2;
  localparam logic [BYTE_W-1:0] END_RST    = 8'd3;
  localparam logic [BYTE_W-1:0] ESCAPE_RST = 8'd27;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_RECV = 2'd1,
    MODE_ESC  = 2'd2,
    MODE_FULL = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_STORED       = 4'd0,
    ST_DONE         = 4'd1,
    ST_ESCAPE       = 4'd2,
    ST_NO_START     = 4'd3,
    ST_STRAY_START  = 4'd4,
    ST_OVERFLOW     = 4'd5,
    ST_NOT_RELEASED = 4'd6,
    ST_READ         = 4'd7,
    ST_RELEASED     = 4'd8
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] start_byte;
    logic [BYTE_W-1:0] end_byte;
    logic [BYTE_W-1:0] escape_byte;
  } cfg_t;

  // classified result, known at accept time
  typedef struct packed {
    status_t          status;
    logic [LEN_W-1:0] frame_length;
    logic             frame_ready;
    logic             rd_hit;
  } res_t;

  // queue entry: result plus the byte read from the store
  typedef struct packed {
    res_t              res;
    logic [BYTE_W-1:0] rd_byte;
  } entry_t;

endpackage : efr_pkg
`default_nettype wire

/* hdl/efr_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// efr_front
// Accepts items, runs the receiver mode machine, writes and reads the frame
// store and hands one registered result per item to the result queue.
// ----------------------------------------------------------------------------
module efr_front #(
  parameter int CAPACITY = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire efr_pkg::cfg_t                 cfg,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [efr_pkg::ACTION_W-1:0]  in_action,
  input  wire logic [efr_pkg::BYTE_W-1:0]    in_rx_byte,
  input  wire logic [efr_pkg::IDX_W-1:0]     in_read_index,
  input  wire logic [efr_pkg::QUEUE_LVL_W-1:0] q_level,
  output logic                               q_push,
  output efr_pkg::entry_t                    q_push_data
);
  import efr_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int XW = (CW > IDX_W) ? CW : IDX_W;
  localparam int LW = (CW > LEN_W) ? CW : LEN_W;
  localparam int OW = QUEUE_LVL_W + 1;

  mode_t             mode_r, mode_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              s1_valid_r;
  res_t              s1_res_r, res_nxt;
  logic [BYTE_W-1:0] rd_byte_r;
  logic [BYTE_W-1:0] mem_r [CAPACITY];

  logic              accept;
  logic              is_recv, is_rel;
  logic              hit_start, hit_end, hit_esc, full;
  logic              wr_en, rd_en, rd_hit;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [XW-1:0]     idx_x, cnt_x;
  logic [LW-1:0]     len_x;
  logic [OW-1:0]     occ;
  status_t           status;

  // room check covers the item still in the read stage
  assign occ      = OW'(q_level) + OW'(s1_valid_r);
  assign in_stall = (occ >= OW'(QUEUE_DEPTH));
  assign accept   = in_valid & ~in_stall;

  // byte classification
  assign is_recv   = (in_action == ACT_RECEIVE);
  assign is_rel    = (in_action == ACT_RELEASE);
  assign hit_start = (in_rx_byte == cfg.start_byte);
  assign hit_end   = (in_rx_byte == cfg.end_byte);
  assign hit_esc   = (in_rx_byte == cfg.escape_byte);
  assign full      = (count_r == CW'(CAPACITY));

  // read lookup against the current length
  assign idx_x   = XW'(in_read_index);
  assign cnt_x   = XW'(count_r);
  assign rd_hit  = (idx_x < cnt_x);
  assign rd_addr = idx_x[AW-1:0];
  assign rd_en   = accept & ~is_recv & ~is_rel & rd_hit;

  // next mode
  always_comb begin
    mode_nxt = mode_r;
    if (accept && is_rel) begin
      mode_nxt = MODE_IDLE;
    end else if (accept && is_recv) begin
      unique case (mode_r)
        MODE_IDLE: mode_nxt = hit_start ? MODE_RECV : MODE_IDLE;
        MODE_RECV: begin
          if (hit_end) begin
            mode_nxt = full ? MODE_IDLE : MODE_FULL;
          end else if (hit_esc) begin
            mode_nxt = full ? MODE_IDLE : MODE_ESC;
          end else if (hit_start) begin
            mode_nxt = MODE_IDLE;
          end else begin
            mode_nxt = full ? MODE_IDLE : MODE_RECV;
          end
        end
        MODE_ESC:  mode_nxt = full ? MODE_IDLE : MODE_RECV;
        MODE_FULL: mode_nxt = MODE_IDLE;
        default:   mode_nxt = MODE_IDLE;
      endcase
    end
  end

  // status, length and store write for the item
  always_comb begin
    status    = ST_READ;
    count_nxt = count_r;
    wr_en     = 1'b0;
    wr_addr   = count_r[AW-1:0];
    if (is_rel) begin
      status = ST_RELEASED;
    end else if (is_recv) begin
      unique case (mode_r)
        MODE_IDLE: begin
          if (hit_start) begin
            status    = ST_STORED;
            wr_en     = 1'b1;
            wr_addr   = '0;
            count_nxt = CW'(1);
          end else begin
            status    = ST_NO_START;
            count_nxt = '0;
          end
        end
        MODE_RECV: begin
          if (hit_start && !hit_end && !hit_esc) begin
            status    = ST_STRAY_START;
            count_nxt = '0;
          end else if (full) begin
            status    = ST_OVERFLOW;
            count_nxt = '0;
          end else begin
            wr_en     = 1'b1;
            count_nxt = count_r + CW'(1);
            if (hit_end) begin
              status = ST_DONE;
            end else if (hit_esc) begin
              status = ST_ESCAPE;
            end else begin
              status = ST_STORED;
            end
          end
        end
        MODE_ESC: begin
          if (full) begin
            status    = ST_OVERFLOW;
            count_nxt = '0;
          end else begin
            status    = ST_STORED;
            wr_en     = 1'b1;
            count_nxt = count_r + CW'(1);
          end
        end
        MODE_FULL: begin
          status    = ST_NOT_RELEASED;
          count_nxt = '0;
        end
        default: begin
          status    = ST_NOT_RELEASED;
          count_nxt = '0;
        end
      endcase
    end
  end

  // result record
  assign len_x = LW'(count_nxt);
  always_comb begin
    res_nxt.status       = status;
    res_nxt.frame_length = len_x[LEN_W-1:0];
    res_nxt.frame_ready  = (mode_nxt == MODE_FULL);
    res_nxt.rd_hit       = ~is_recv & ~is_rel & rd_hit;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_IDLE;
      count_r    <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      mode_r     <= mode_nxt;
      s1_valid_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  // result stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res_r <= res_nxt;
    end
  end

  // frame store, one access a cycle
  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      mem_r[wr_addr] <= in_rx_byte;
    end
    if (rd_en) begin
      rd_byte_r <= mem_r[rd_addr];
    end
  end

  // push to the result queue
  assign q_push = s1_valid_r;
  always_comb begin
    q_push_data.res     = s1_res_r;
    q_push_data.rd_byte = rd_byte_r;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("frame length beyond capacity");

  a_open_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r != MODE_IDLE |-> count_r != '0)
    else $error("open frame with empty store");
`endif

endmodule : efr_front
`default_nettype wire

/* hdl/efr_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// efr_queue
// Short result queue that decouples the classifying front from the output
// register; reports its fill level for the front's room check.
// ----------------------------------------------------------------------------
module efr_queue (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            push,
  input  wire efr_pkg::entry_t                 push_data,
  input  wire logic                            pop,
  output efr_pkg::entry_t                      head,
  output logic                                 empty,
  output logic [efr_pkg::QUEUE_LVL_W-1:0]      level
);
  import efr_pkg::*;

  entry_t                 entries_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [QUEUE_LVL_W-1:0] level_r, level_nxt;

  assign head  = entries_r[rd_ptr_r];
  assign empty = (level_r == '0);
  assign level = level_r;

  // fill level
  always_comb begin
    level_nxt = level_r;
    if (push && !pop) begin
      level_nxt = level_r + QUEUE_LVL_W'(1);
    end else if (!push && pop) begin
      level_nxt = level_r - QUEUE_LVL_W'(1);
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      level_r <= level_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QUEUE_AW'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> level_r < QUEUE_LVL_W'(QUEUE_DEPTH))
    else $error("result queue overrun");

  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> level_r != '0)
    else $error("result queue underrun");
`endif

endmodule : efr_queue
`default_nettype wire

/* hdl/efr_out.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// efr_out
// Output register of the result channel: takes the queue head when the
// register is free or being taken, and masks read data beyond the length.
// ----------------------------------------------------------------------------
module efr_out (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire efr_pkg::entry_t                head,
  input  wire logic                           q_empty,
  output logic                                pop,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [efr_pkg::STATUS_W-1:0]        out_status,
  output logic [efr_pkg::LEN_W-1:0]           out_frame_length,
  output logic                                out_frame_ready,
  output logic [efr_pkg::BYTE_W-1:0]          out_read_data
);
  import efr_pkg::*;

  logic                valid_r, valid_nxt;
  logic [STATUS_W-1:0] status_r;
  logic [LEN_W-1:0]    length_r;
  logic                ready_r;
  logic [BYTE_W-1:0]   data_r;

  // load when the register is empty or its item leaves this cycle
  assign pop = ~q_empty & (~valid_r | ~out_stall);

  always_comb begin
    valid_nxt = valid_r;
    if (pop) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload, read data zero unless a read item's index was inside the frame
  always_ff @(posedge clk) begin
    if (pop) begin
      status_r <= head.res.status;
      length_r <= head.res.frame_length;
      ready_r  <= head.res.frame_ready;
      data_r   <= head.res.rd_hit ? head.rd_byte : '0;
    end
  end

  assign out_valid        = valid_r;
  assign out_status       = status_r;
  assign out_frame_length = length_r;
  assign out_frame_ready  = ready_r;
  assign out_read_data    = data_r;

endmodule : efr_out
`default_nettype wire

/* hdl/escaped_frame_receiver.sv */
`default_nettype none
// Path: a result passes the store-read stage, a result queue entry and the
// output register before it shows on out_valid.
// Throughput: one item per cycle; in_stall rises only when the 4-entry result
// queue plus the item in the store-read stage fill it up.
// Reset (synchronous, rst_n low): receiver idle, length zero, queue and
// output empty, delimiters back to 2/3/27; frame store contents are kept.
// ----------------------------------------------------------------------------
// escaped_frame_receiver
// Start/end delimited frame receiver with escape byte: gathers one frame into
// a store, reports per-item status and serves reads of the stored frame.
// ----------------------------------------------------------------------------
module escaped_frame_receiver #(
  parameter int CAPACITY = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [efr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [efr_pkg::BYTE_W-1:0]      cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [efr_pkg::ACTION_W-1:0]    in_action,
  input  wire logic [efr_pkg::BYTE_W-1:0]      in_rx_byte,
  input  wire logic [efr_pkg::IDX_W-1:0]       in_read_index,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [efr_pkg::STATUS_W-1:0]         out_status,
  output logic [efr_pkg::LEN_W-1:0]            out_frame_length,
  output logic                                 out_frame_ready,
  output logic [efr_pkg::BYTE_W-1:0]           out_read_data
);
  import efr_pkg::*;

  cfg_t                   cfg_r, cfg_nxt;
  logic                   q_push, q_pop, q_empty;
  entry_t                 q_push_data, q_head;
  logic [QUEUE_LVL_W-1:0] q_level;

  // config register decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_START:  cfg_nxt.start_byte  = cfg_data;
        CFG_END:    cfg_nxt.end_byte    = cfg_data;
        CFG_ESCAPE: cfg_nxt.escape_byte = cfg_data;
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte  <= START_RST;
      cfg_r.end_byte    <= END_RST;
      cfg_r.escape_byte <= ESCAPE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // classify, store and look up
  efr_front #(
    .CAPACITY (CAPACITY)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_rx_byte    (in_rx_byte),
    .in_read_index (in_read_index),
    .q_level       (q_level),
    .q_push        (q_push),
    .q_push_data   (q_push_data)
  );

  // result queue
  efr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .level     (q_level)
  );

  // output register
  efr_out u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (q_head),
    .q_empty          (q_empty),
    .pop              (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_frame_length (out_frame_length),
    .out_frame_ready  (out_frame_ready),
    .out_read_data    (out_read_data)
  );

endmodule : escaped_frame_receiver
`default_nettype wire

/* test/escaped_frame_receiver_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escaped_frame_receiver_tb
// Self-checking bench for the escaped frame receiver. Feeds receive, read and
// release items with random gaps, stalls the result side at random, predicts
// every result with a behavioral copy of the deframer and compares each
// result field by field. Runs through several delimiter settings, including
// the reset values, the byte extremes and settings where delimiters coincide.
// ----------------------------------------------------------------------------
module escaped_frame_receiver_tb;
  import efr_pkg::*;

  localparam int FRAME_CAP     = 32;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 85;
  localparam int PRINT_CAP     = 40;

  // code 3 is not a defined action, the block treats it as a read
  localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

  // delimiter settings per random phase: start, end, escape
  localparam logic [RANDOM_PHASES*24-1:0] PHASE_CFG = {
    24'h7E7D7C,  // distinct, mid range
    24'h00FF80,  // byte extremes
    24'hFF0001,
    24'h050509,  // start equals end
    24'h050909,  // end equals escape
    24'h090509,  // start equals escape
    24'h010101,  // all three equal
    24'h807F55,
    24'h02031B,  // back to reset values
    24'hAA55FF
  };

  typedef struct {
    logic [ACTION_W-1:0] action;
    logic [BYTE_W-1:0]   rx_byte;
    logic [IDX_W-1:0]    read_index;
    int unsigned         gap;
  } rx_item_t;

  typedef struct packed {
    status_t           status;
    logic [LEN_W-1:0]  frame_length;
    logic              frame_ready;
    logic [BYTE_W-1:0] read_data;
  } frame_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BYTE_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [ACTION_W-1:0]  in_action = '0;
  logic [BYTE_W-1:0]    in_rx_byte = '0;
  logic [IDX_W-1:0]     in_read_index = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [STATUS_W-1:0]  out_status;
  logic [LEN_W-1:0]     out_frame_length;
  logic                 out_frame_ready;
  logic [BYTE_W-1:0]    out_read_data;

  // pending items and results still owed by the block
  rx_item_t      byte_feed_q[$];
  frame_result_t status_due_q[$];
  frame_result_t due;
  int unsigned   err_count = 0;
  int unsigned   result_count = 0;
  int unsigned   fed_count = 0;
  int unsigned   cycle_count = 0;
  bit            quiet = 1'b0;

  // deframer copy: delimiters, mode, store and length
  logic [BYTE_W-1:0] sof_byte = START_RST;
  logic [BYTE_W-1:0] eof_byte = END_RST;
  logic [BYTE_W-1:0] esc_byte = ESCAPE_RST;
  mode_t             rx_mode = MODE_IDLE;
  logic [BYTE_W-1:0] rx_store [FRAME_CAP];
  int unsigned       rx_count = 0;

  // driver state
  rx_item_t    next_item;
  bit          item_held = 1'b0;
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;

  escaped_frame_receiver #(
    .CAPACITY(FRAME_CAP)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_action(in_action),
    .in_rx_byte(in_rx_byte),
    .in_read_index(in_read_index),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_frame_length(out_frame_length),
    .out_frame_ready(out_frame_ready),
    .out_read_data(out_read_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // idle cycles before an item or between results; none in quiet phases
  function automatic int unsigned pick_wait();
    if (quiet || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 14);
  endfunction

  // random byte, often one of the current delimiters
  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return sof_byte;
      1: return eof_byte;
      2: return esc_byte;
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  // error exit: back to idle with an empty store
  function automatic status_t abort_frame(status_t code);
    rx_mode = MODE_IDLE;
    rx_count = 0;
    return code;
  endfunction

  // store write with capacity check, then move to the given mode
  function automatic status_t put_byte(logic [BYTE_W-1:0] b, mode_t nxt, status_t code);
    if (rx_count >= FRAME_CAP) return abort_frame(ST_OVERFLOW);
    rx_store[rx_count] = b;
    rx_count++;
    rx_mode = nxt;
    return code;
  endfunction

  // classify one received byte; end wins over escape, escape over start
  function automatic status_t take_byte(logic [BYTE_W-1:0] b);
    case (rx_mode)
      MODE_IDLE: begin
        if (b != sof_byte) return abort_frame(ST_NO_START);
        rx_count = 0;
        return put_byte(b, MODE_RECV, ST_STORED);
      end
      MODE_RECV: begin
        if (b == eof_byte) return put_byte(b, MODE_FULL, ST_DONE);
        if (b == esc_byte) return put_byte(b, MODE_ESC, ST_ESCAPE);
        if (b == sof_byte) return abort_frame(ST_STRAY_START);
        return put_byte(b, MODE_RECV, ST_STORED);
      end
      MODE_ESC: return put_byte(b, MODE_RECV, ST_STORED);
      default: return abort_frame(ST_NOT_RELEASED);
    endcase
  endfunction

  // expected result of one accepted item
  function automatic frame_result_t deframe_step(logic [ACTION_W-1:0] act,
                                                 logic [BYTE_W-1:0] b,
                                                 logic [IDX_W-1:0] idx);
    frame_result_t r;
    r.read_data = '0;
    if (act == ACT_RECEIVE) begin
      r.status = take_byte(b);
    end else if (act == ACT_RELEASE) begin
      rx_mode = MODE_IDLE;
      r.status = ST_RELEASED;
    end else begin
      if (idx < rx_count) r.read_data = rx_store[idx];
      r.status = ST_READ;
    end
    r.frame_length = rx_count[LEN_W-1:0];
    r.frame_ready = (rx_mode == MODE_FULL);
    return r;
  endfunction

  task automatic queue_item(logic [ACTION_W-1:0] act, logic [BYTE_W-1:0] b,
                            logic [IDX_W-1:0] idx);
    rx_item_t it;
    it.action = act;
    it.rx_byte = b;
    it.read_index = idx;
    it.gap = pick_wait();
    byte_feed_q.push_back(it);
    fed_count++;
  endtask

  task automatic queue_byte(logic [BYTE_W-1:0] b);
    queue_item(ACT_RECEIVE, b, IDX_W'($urandom_range(0, 31)));
  endtask

  task automatic flag(string what, int unsigned got, int unsigned want);
    if (err_count < PRINT_CAP)
      $display("mismatch on result %0d: %s got %0d want %0d", result_count, what, got, want);
    err_count++;
  endtask

  // wait until the sender is empty and every result is back, then drain
  task automatic settle();
    do @(negedge clk);
    while (byte_feed_q.size() != 0 || item_held || in_valid || status_due_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // driver: predicts on accept, then shows the next item after its gap
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      item_held = 1'b0;
    end else begin
      if (in_valid && !in_stall)
        status_due_q.push_back(deframe_step(in_action, in_rx_byte, in_read_index));
      if (!in_valid || !in_stall) begin
        if (!item_held && byte_feed_q.size() > 0) begin
          next_item = byte_feed_q.pop_front();
          item_held = 1'b1;
          gap_left = next_item.gap;
        end
        if (item_held && gap_left == 0) begin
          in_action <= next_item.action;
          in_rx_byte <= next_item.rx_byte;
          in_read_index <= next_item.read_index;
          in_valid <= 1'b1;
          item_held = 1'b0;
        end else begin
          in_valid <= 1'b0;
          if (item_held) gap_left--;
        end
      end
    end
  end

  // monitor: checks each result against the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        result_count++;
        if (status_due_q.size() == 0) begin
          flag("unexpected result, status", 32'(out_status), 0);
        end else begin
          due = status_due_q.pop_front();
          if (out_status !== due.status)
            flag("status", 32'(out_status), 32'(due.status));
          if (out_frame_length !== due.frame_length)
            flag("frame_length", 32'(out_frame_length), 32'(due.frame_length));
          if (out_frame_ready !== due.frame_ready)
            flag("frame_ready", 32'(out_frame_ready), 32'(due.frame_ready));
          if (out_read_data !== due.read_data)
            flag("read_data", 32'(out_read_data), 32'(due.read_data));
        end
        hold_left = pick_wait();
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    cfg_t        setting;
    int unsigned fed_mark;
    int unsigned body;
    int unsigned flen;
    logic [BYTE_W-1:0] b;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed items with reset delimiters
    queue_byte(8'h55);                        // byte while idle
    queue_item(ACT_READ, 8'hFF, 5'd0);        // read of an empty store
    queue_byte(START_RST);
    queue_byte(8'hFF);
    queue_byte(8'h00);
    queue_byte(ESCAPE_RST);
    queue_byte(END_RST);                      // escaped end byte is literal
    queue_byte(START_RST);                    // stray start inside a frame
    queue_byte(START_RST);
    queue_byte(ESCAPE_RST);
    queue_byte(ESCAPE_RST);                   // escaped escape
    queue_byte(8'hA5);
    queue_byte(END_RST);                      // frame complete
    queue_item(ACT_READ, 8'h00, 5'd0);
    queue_item(ACT_READ, 8'hFF, 5'd4);
    queue_item(ACT_READ, 8'h00, 5'd31);       // beyond length reads zero
    queue_item(ACT_SPARE, 8'hFF, 5'd1);
    queue_byte(8'h11);                        // byte while frame waits
    queue_item(ACT_RELEASE, 8'h00, 5'd0);     // release while idle
    queue_byte(START_RST);
    queue_item(ACT_RELEASE, 8'hFF, 5'd31);    // release mid frame keeps store
    queue_item(ACT_READ, 8'h5A, 5'd0);
    queue_byte(END_RST);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      setting = PHASE_CFG[(RANDOM_PHASES - 1 - p) * 24 +: 24];
      cfg_we <= 1'b1;
      cfg_index <= CFG_START;
      cfg_data <= setting.start_byte;
      @(posedge clk);
      cfg_index <= CFG_END;
      cfg_data <= setting.end_byte;
      @(posedge clk);
      cfg_index <= CFG_ESCAPE;
      cfg_data <= setting.escape_byte;
      @(posedge clk);
      cfg_we <= 1'b0;
      sof_byte = setting.start_byte;
      eof_byte = setting.end_byte;
      esc_byte = setting.escape_byte;
      @(negedge clk);
      quiet = ($urandom_range(0, 3) == 0);

      fed_mark = fed_count;
      while (fed_count - fed_mark < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) < 7) begin
          // frame: start, escaped body, end, a few reads, release
          body = ($urandom_range(0, 7) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 12);
          queue_byte(sof_byte);
          flen = 1;
          for (int k = 0; k < body; k++) begin
            b = pick_byte();
            if (b == sof_byte || b == eof_byte || b == esc_byte || $urandom_range(0, 9) == 0) begin
              queue_byte(esc_byte);
              flen++;
            end
            queue_byte(b);
            flen++;
          end
          // now and then the end byte goes missing
          if ($urandom_range(0, 9) != 0) begin
            queue_byte(eof_byte);
            flen++;
          end
          if (flen > FRAME_CAP) flen = FRAME_CAP;
          repeat ($urandom_range(1, 4))
            queue_item(ACT_READ, BYTE_W'($urandom_range(0, 255)),
                       IDX_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                          : $urandom_range(0, flen - 1)));
          if ($urandom_range(0, 7) == 0) queue_byte(pick_byte());
          queue_item(ACT_RELEASE, BYTE_W'($urandom_range(0, 255)),
                     IDX_W'($urandom_range(0, 31)));
        end else begin
          // noise: any action, any content
          repeat ($urandom_range(1, 4))
            queue_item(ACTION_W'($urandom_range(0, 3)), pick_byte(),
                       IDX_W'($urandom_range(0, 31)));
        end
      end
    end

    settle();
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
